[design/rmq_pkg.sv]
// Shared constants, widths and types for the rotation matrix to quaternion pipeline.
// No dependencies; every other design file refers to this package by scoped names.
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int IN_W      = 16;
   localparam int OUT_W     = 16;
   localparam int C_W       = IN_W + 2;
   localparam int MAG_W     = C_W - 1;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int Q_W       = SQ_W + 2;
   localparam int SQRT_W    = Q_W / 2;
   localparam int R_W       = Q_W + 1;
   localparam int QBITS     = FRAC_BITS + 1;
   localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
   localparam int REM_W     = SQRT_W + 1;
   localparam int PROD_W    = 2 * IN_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int CMP_W     = SUM_W + 6;

   localparam logic signed [C_W-1:0]   ONE_FX = C_W'(1) <<< FRAC_BITS;
   localparam logic signed [CMP_W-1:0] ONE_SQ = CMP_W'(1) <<< (2 * FRAC_BITS);

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_DEGEN  = 2'd2;

   typedef logic signed [C_W-1:0] comp_type;

   typedef struct packed {
      logic                  valid;
      logic                  reject;
      logic [3:0]            neg;
      logic [3:0][MAG_W-1:0] mag;
   } sq_side_type;

   typedef struct packed {
      logic       valid;
      logic       reject;
      logic       degen;
      logic [3:0] neg;
   } div_side_type;

endpackage

[design/rmq_isqrt_pipe.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on rmq_pkg for widths and the side-band struct carried alongside.
module rmq_isqrt_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [rmq_pkg::Q_W-1:0]   in_q,
   input  rmq_pkg::sq_side_type      in_side,
   output logic [rmq_pkg::SQRT_W-1:0] out_n,
   output rmq_pkg::sq_side_type      out_side
);

   localparam int STAGES = rmq_pkg::SQRT_W;

   logic [rmq_pkg::R_W-1:0] v_src [0:STAGES];
   logic [rmq_pkg::R_W-1:0] r_src [0:STAGES];
   rmq_pkg::sq_side_type    s_src [0:STAGES];
   logic [rmq_pkg::R_W-1:0] v_in  [0:STAGES-1];
   logic [rmq_pkg::R_W-1:0] r_in  [0:STAGES-1];
   logic [rmq_pkg::R_W-1:0] v_ff  [0:STAGES-1];
   logic [rmq_pkg::R_W-1:0] r_ff  [0:STAGES-1];
   rmq_pkg::sq_side_type    s_ff  [0:STAGES-1];

   always_comb begin
      logic [rmq_pkg::R_W-1:0] bitv;
      logic [rmq_pkg::R_W-1:0] sum;
      v_src[0] = rmq_pkg::R_W'(in_q);
      r_src[0] = '0;
      s_src[0] = in_side;
      for (int i = 0; i < STAGES; i++) begin
         v_src[i+1] = v_ff[i];
         r_src[i+1] = r_ff[i];
         s_src[i+1] = s_ff[i];
      end
      for (int i = 0; i < STAGES; i++) begin
         bitv = rmq_pkg::R_W'(1) << (2 * (STAGES - 1 - i));
         sum  = r_src[i] + bitv;
         if (v_src[i] >= sum) begin
            v_in[i] = v_src[i] - sum;
            r_in[i] = (r_src[i] >> 1) + bitv;
         end else begin
            v_in[i] = v_src[i];
            r_in[i] = r_src[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (reset) begin
            s_ff[i].valid <= 1'b0;
         end else if (en) begin
            s_ff[i] <= s_src[i];
            v_ff[i] <= v_in[i];
            r_ff[i] <= r_in[i];
         end
      end
   end

   assign out_n    = r_ff[STAGES-1][rmq_pkg::SQRT_W-1:0];
   assign out_side = s_ff[STAGES-1];

endmodule

[design/rmq_div_pipe.sv]
// Four-lane pipelined restoring divider giving round(mag * 2^F / n), one bit per stage.
// Depends on rmq_pkg for widths and the side-band struct carried alongside.
module rmq_div_pipe (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic [rmq_pkg::SQRT_W-1:0]          in_n,
   input  logic [3:0][rmq_pkg::MAG_W-1:0]      in_mag,
   input  rmq_pkg::div_side_type               in_side,
   output logic [3:0][rmq_pkg::QBITS-1:0]      out_quo,
   output rmq_pkg::div_side_type               out_side
);

   localparam int STAGES = rmq_pkg::QBITS;

   logic [3:0][rmq_pkg::REM_W-1:0] rem_src [0:STAGES];
   logic [3:0][rmq_pkg::QBITS-1:0] quo_src [0:STAGES];
   logic [3:0][rmq_pkg::QBITS-1:0] low_src [0:STAGES];
   logic [rmq_pkg::SQRT_W-1:0]     n_src   [0:STAGES];
   rmq_pkg::div_side_type          s_src   [0:STAGES];

   logic [3:0][rmq_pkg::REM_W-1:0] rem_in [0:STAGES-1];
   logic [3:0][rmq_pkg::QBITS-1:0] quo_in [0:STAGES-1];
   logic [3:0][rmq_pkg::REM_W-1:0] rem_ff [0:STAGES-1];
   logic [3:0][rmq_pkg::QBITS-1:0] quo_ff [0:STAGES-1];
   logic [3:0][rmq_pkg::QBITS-1:0] low_ff [0:STAGES-1];
   logic [rmq_pkg::SQRT_W-1:0]     n_ff   [0:STAGES-1];
   rmq_pkg::div_side_type          s_ff   [0:STAGES-1];

   always_comb begin
      logic [rmq_pkg::NUM_W-1:0] num;
      logic [rmq_pkg::REM_W-1:0] t;
      logic                      ge;
      // Quotient never exceeds 2^F, so the top numerator bits start below n.
      for (int l = 0; l < 4; l++) begin
         num = (rmq_pkg::NUM_W'(in_mag[l]) << rmq_pkg::FRAC_BITS)
             + rmq_pkg::NUM_W'(in_n >> 1);
         rem_src[0][l] = rmq_pkg::REM_W'(num >> rmq_pkg::QBITS);
         low_src[0][l] = num[rmq_pkg::QBITS-1:0];
         quo_src[0][l] = '0;
      end
      n_src[0] = in_n;
      s_src[0] = in_side;
      for (int i = 0; i < STAGES; i++) begin
         rem_src[i+1] = rem_ff[i];
         quo_src[i+1] = quo_ff[i];
         low_src[i+1] = low_ff[i];
         n_src[i+1]   = n_ff[i];
         s_src[i+1]   = s_ff[i];
      end
      for (int i = 0; i < STAGES; i++) begin
         for (int l = 0; l < 4; l++) begin
            t  = {rem_src[i][l][rmq_pkg::REM_W-2:0], low_src[i][l][STAGES-1-i]};
            ge = (t >= {1'b0, n_src[i]});
            rem_in[i][l] = ge ? (t - {1'b0, n_src[i]}) : t;
            quo_in[i][l] = {quo_src[i][l][rmq_pkg::QBITS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (reset) begin
            s_ff[i].valid <= 1'b0;
         end else if (en) begin
            s_ff[i]   <= s_src[i];
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            low_ff[i] <= low_src[i];
            n_ff[i]   <= n_src[i];
         end
      end
   end

   assign out_quo  = quo_ff[STAGES-1];
   assign out_side = s_ff[STAGES-1];

endmodule

[design/rotation_matrix_to_quaternion_top.sv]
// Rotation matrix to quaternion, Shepperd's method, fully pipelined in fixed point.
// Depth: 38 register stages, from the input register through to the output register.
// Throughput: one item per cycle while no result waits; the 18-stage square root and 15-stage divider set the depth.
// The whole pipeline holds while a result waits, so req_tready is high unless a result waits without rsp_tready.
// Reset (synchronous, active high) clears all valid bits; the block keeps no other state.
// Depends on rmq_pkg, rmq_isqrt_pipe and rmq_div_pipe.
module rotation_matrix_to_quaternion_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // From bit 0: forward_x, forward_y, forward_z, left_x, left_y, left_z, up_x, up_y, up_z.
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // From bit 0: quat_x, quat_y, quat_z, quat_w, status (2 bits), then zero fill.
   output logic [71:0]  rsp_tdata
);

   localparam int IW = rmq_pkg::IN_W;

   // One enable for every stage: a stalled result freezes the whole pipeline,
   // so nothing is lost or repeated.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Stage 0: registered input entries.
   logic                        v0_ff;
   logic signed [IW-1:0]        m_ff [0:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         for (int k = 0; k < 9; k++) begin
            m_ff[k] <= req_tdata[k*IW +: IW];
         end
      end
   end

   // Stage 1: the eighteen entry products for the basis test, and the Shepperd
   // components scaled by 2*sqrt(K), so no root is needed before normalizing.
   logic signed [rmq_pkg::C_W-1:0] e00, e10, e20, e01, e11, e21, e02, e12, e22;
   logic signed [rmq_pkg::C_W-1:0] trace;
   rmq_pkg::comp_type              c_in [0:3];
   logic signed [rmq_pkg::PROD_W-1:0] p_in  [0:17];
   logic signed [rmq_pkg::PROD_W-1:0] p_ff  [0:17];
   rmq_pkg::comp_type                 c1_ff [0:3];
   logic                              v1_ff;

   always_comb begin
      e00 = rmq_pkg::C_W'(m_ff[0]);
      e10 = rmq_pkg::C_W'(m_ff[1]);
      e20 = rmq_pkg::C_W'(m_ff[2]);
      e01 = rmq_pkg::C_W'(m_ff[3]);
      e11 = rmq_pkg::C_W'(m_ff[4]);
      e21 = rmq_pkg::C_W'(m_ff[5]);
      e02 = rmq_pkg::C_W'(m_ff[6]);
      e12 = rmq_pkg::C_W'(m_ff[7]);
      e22 = rmq_pkg::C_W'(m_ff[8]);
      trace = e00 + e11 + e22;
      priority if (trace > 0) begin
         c_in[0] = e21 - e12;
         c_in[1] = e02 - e20;
         c_in[2] = e10 - e01;
         c_in[3] = rmq_pkg::ONE_FX + trace;
      end else if (e00 > e11 && e00 > e22) begin
         c_in[0] = rmq_pkg::ONE_FX + e00 - e11 - e22;
         c_in[1] = e01 + e10;
         c_in[2] = e02 + e20;
         c_in[3] = e21 - e12;
      end else if (e11 > e22) begin
         c_in[0] = e01 + e10;
         c_in[1] = rmq_pkg::ONE_FX + e11 - e00 - e22;
         c_in[2] = e12 + e21;
         c_in[3] = e02 - e20;
      end else begin
         c_in[0] = e02 + e20;
         c_in[1] = e12 + e21;
         c_in[2] = rmq_pkg::ONE_FX + e22 - e00 - e11;
         c_in[3] = e10 - e01;
      end
      // Squares per column, then forward.left, forward.up, left.up dot terms.
      for (int k = 0; k < 9; k++) begin
         p_in[k] = m_ff[k] * m_ff[k];
      end
      for (int k = 0; k < 3; k++) begin
         p_in[9 + k]  = m_ff[k] * m_ff[3 + k];
         p_in[12 + k] = m_ff[k] * m_ff[6 + k];
         p_in[15 + k] = m_ff[3 + k] * m_ff[6 + k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
         p_ff  <= p_in;
         c1_ff <= c_in;
      end
   end

   // Stage 2: basis limits and the component squares.
   logic signed [rmq_pkg::CMP_W-1:0] len_s [0:2];
   logic signed [rmq_pkg::CMP_W-1:0] dot_s [0:2];
   logic signed [rmq_pkg::CMP_W-1:0] dot_m [0:2];
   logic                             bad;
   logic [3:0][rmq_pkg::MAG_W-1:0]   mag_in;
   logic [3:0]                       neg_in;
   logic [rmq_pkg::SQ_W-1:0]         sq_in [0:3];
   logic [rmq_pkg::SQ_W-1:0]         sq_ff [0:3];
   logic [3:0][rmq_pkg::MAG_W-1:0]   mag2_ff;
   logic [3:0]                       neg2_ff;
   logic                             rej2_ff;
   logic                             v2_ff;

   always_comb begin
      bad = 1'b0;
      for (int k = 0; k < 3; k++) begin
         len_s[k] = rmq_pkg::CMP_W'(p_ff[3*k]) + rmq_pkg::CMP_W'(p_ff[3*k + 1])
                  + rmq_pkg::CMP_W'(p_ff[3*k + 2]);
         dot_s[k] = rmq_pkg::CMP_W'(p_ff[9 + 3*k]) + rmq_pkg::CMP_W'(p_ff[10 + 3*k])
                  + rmq_pkg::CMP_W'(p_ff[11 + 3*k]);
         dot_m[k] = (dot_s[k] < 0) ? -dot_s[k] : dot_s[k];
         if (5 * len_s[k] < 4 * rmq_pkg::ONE_SQ) bad = 1'b1;
         if (5 * len_s[k] > 6 * rmq_pkg::ONE_SQ) bad = 1'b1;
         if (!(5 * dot_m[k] < rmq_pkg::ONE_SQ)) bad = 1'b1;
      end
      for (int l = 0; l < 4; l++) begin
         neg_in[l] = c1_ff[l][rmq_pkg::C_W-1];
         mag_in[l] = neg_in[l] ? rmq_pkg::MAG_W'(-c1_ff[l])
                               : rmq_pkg::MAG_W'(c1_ff[l]);
         sq_in[l]  = mag_in[l] * mag_in[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff   <= v1_ff;
         rej2_ff <= bad;
         mag2_ff <= mag_in;
         neg2_ff <= neg_in;
         sq_ff   <= sq_in;
      end
   end

   // Stage 3: squared length of the unnormalized quaternion.
   logic [rmq_pkg::Q_W-1:0] q2_ff;
   rmq_pkg::sq_side_type    s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         q2_ff <= rmq_pkg::Q_W'(sq_ff[0]) + rmq_pkg::Q_W'(sq_ff[1])
                + rmq_pkg::Q_W'(sq_ff[2]) + rmq_pkg::Q_W'(sq_ff[3]);
         s3_ff.valid  <= v2_ff;
         s3_ff.reject <= rej2_ff;
         s3_ff.neg    <= neg2_ff;
         s3_ff.mag    <= mag2_ff;
      end
   end

   // Square root, then one divider lane per component.
   logic [rmq_pkg::SQRT_W-1:0]     root_n;
   rmq_pkg::sq_side_type           root_side;
   rmq_pkg::div_side_type          div_in_side;
   logic [3:0][rmq_pkg::QBITS-1:0] quo;
   rmq_pkg::div_side_type          div_side;

   rmq_isqrt_pipe u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_q     (q2_ff),
      .in_side  (s3_ff),
      .out_n    (root_n),
      .out_side (root_side)
   );

   always_comb begin
      div_in_side.valid  = root_side.valid;
      div_in_side.reject = root_side.reject;
      div_in_side.degen  = (root_n == '0);
      div_in_side.neg    = root_side.neg;
   end

   rmq_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_n     (root_n),
      .in_mag   (root_side.mag),
      .in_side  (div_in_side),
      .out_quo  (quo),
      .out_side (div_side)
   );

   // Output register: saturate, restore sign, or substitute the identity.
   logic [3:0][rmq_pkg::OUT_W-1:0] q_in;
   logic [1:0]                     st_in;
   logic [3:0][rmq_pkg::OUT_W-1:0] q_ff;
   logic [1:0]                     st_ff;
   logic                           vo_ff;

   always_comb begin
      logic [rmq_pkg::OUT_W-1:0] t;
      for (int l = 0; l < 4; l++) begin
         t = rmq_pkg::OUT_W'(quo[l]);
         if (quo[l] > rmq_pkg::QBITS'(rmq_pkg::ONE_FX)) begin
            t = rmq_pkg::OUT_W'(rmq_pkg::ONE_FX);
         end
         q_in[l] = div_side.neg[l] ? -t : t;
      end
      st_in = rmq_pkg::STATUS_OK;
      if (div_side.reject || div_side.degen) begin
         q_in  = '0;
         q_in[3] = rmq_pkg::OUT_W'(rmq_pkg::ONE_FX);
         st_in = div_side.reject ? rmq_pkg::STATUS_REJECT : rmq_pkg::STATUS_DEGEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= div_side.valid;
         q_ff  <= q_in;
         st_ff <= st_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {6'd0, st_ff, q_ff[3], q_ff[2], q_ff[1], q_ff[0]};

   // A rejected basis always leaves as the identity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff == rmq_pkg::STATUS_REJECT |->
         q_ff[0] == '0 && q_ff[1] == '0 && q_ff[2] == '0
         && q_ff[3] == rmq_pkg::OUT_W'(rmq_pkg::ONE_FX))
      else $error("rejected basis did not give identity");

   // The x and w components of a normalized result never exceed one in magnitude.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff == rmq_pkg::STATUS_OK |->
         $signed(q_ff[0]) <= $signed(rmq_pkg::OUT_W'(rmq_pkg::ONE_FX))
         && $signed(q_ff[0]) >= -$signed(rmq_pkg::OUT_W'(rmq_pkg::ONE_FX))
         && $signed(q_ff[3]) <= $signed(rmq_pkg::OUT_W'(rmq_pkg::ONE_FX))
         && $signed(q_ff[3]) >= -$signed(rmq_pkg::OUT_W'(rmq_pkg::ONE_FX)))
      else $error("quaternion component out of range");

   // The status code is only ever one of the three defined values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> st_ff <= rmq_pkg::STATUS_DEGEN)
      else $error("undefined status code");

   // A stalled pipeline holds every stage, including the root output.
   assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(root_n) && $stable(root_side.valid))
      else $error("pipeline moved during a stall");

endmodule

[tb/sv/rotation_matrix_to_quaternion_top_tb.sv]
// Testbench for the rotation matrix to quaternion pipeline: directed and random bases.
// A scoreboard class predicts each quaternion in exact integer arithmetic and checks results.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_top.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top_tb;

   localparam int STALL_LIMIT = 2000;

   // One expected result: four quaternion components and the status code.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] qw;
      logic [15:0] qz;
      logic [15:0] qy;
      logic [15:0] qx;
   } quat_result_type;

   // Exact magnitude of a signed value.
   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Integer square root, floor, by bit-pair restoring method.
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit length_in_range(longint x, longint y, longint z);
      longint l, one_sq;
      one_sq = longint'(1) << (2 * rmq_pkg::FRAC_BITS);
      l = x * x + y * y + z * z;
      return !(5 * l < 4 * one_sq) && !(5 * l > 6 * one_sq);
   endfunction

   function automatic bit dot_small(longint ax, longint ay, longint az,
                                    longint bx, longint by, longint bz);
      longint one_sq;
      one_sq = longint'(1) << (2 * rmq_pkg::FRAC_BITS);
      return longint'(5 * abs64(ax * bx + ay * by + az * bz)) < one_sq;
   endfunction

   function automatic logic [15:0] scale_unit(longint c, longint unsigned n);
      longint unsigned t;
      t = ((abs64(c) << rmq_pkg::FRAC_BITS) + n / 2) / n;
      if (t > (64'd1 << rmq_pkg::FRAC_BITS)) t = 64'd1 << rmq_pkg::FRAC_BITS;
      if (c < 0) t = -t;
      return t[15:0];
   endfunction

   // Predicts the quaternion for one basis packed as in req_tdata.
   function automatic quat_result_type predict_quaternion(logic [143:0] basis);
      longint m[9];
      longint c[4];
      longint one, trace;
      longint unsigned q2, n;
      quat_result_type r;
      for (int i = 0; i < 9; i++) m[i] = longint'($signed(basis[16*i +: 16]));
      // m[0..2] forward = m00 m10 m20, m[3..5] left = m01 m11 m21, m[6..8] up = m02 m12 m22
      one = longint'(1) << rmq_pkg::FRAC_BITS;
      r = '0;
      r.qw = 16'(one);
      if (!length_in_range(m[0], m[1], m[2]) || !length_in_range(m[3], m[4], m[5]) ||
          !length_in_range(m[6], m[7], m[8]) ||
          !dot_small(m[0], m[1], m[2], m[3], m[4], m[5]) ||
          !dot_small(m[0], m[1], m[2], m[6], m[7], m[8]) ||
          !dot_small(m[3], m[4], m[5], m[6], m[7], m[8])) begin
         r.status = rmq_pkg::STATUS_REJECT;
         return r;
      end
      trace = m[0] + m[4] + m[8];
      if (trace > 0) begin
         c[0] = m[5] - m[7]; c[1] = m[6] - m[2]; c[2] = m[1] - m[3]; c[3] = one + trace;
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         c[0] = one + m[0] - m[4] - m[8]; c[1] = m[3] + m[1];
         c[2] = m[6] + m[2]; c[3] = m[5] - m[7];
      end else if (m[4] > m[8]) begin
         c[0] = m[3] + m[1]; c[1] = one + m[4] - m[0] - m[8];
         c[2] = m[7] + m[5]; c[3] = m[6] - m[2];
      end else begin
         c[0] = m[6] + m[2]; c[1] = m[7] + m[5];
         c[2] = one + m[8] - m[0] - m[4]; c[3] = m[1] - m[3];
      end
      q2 = 0;
      for (int i = 0; i < 4; i++) q2 += abs64(c[i]) * abs64(c[i]);
      n = int_sqrt(q2);
      if (n == 0) begin
         r.status = rmq_pkg::STATUS_DEGEN;
         return r;
      end
      r.qx = scale_unit(c[0], n);
      r.qy = scale_unit(c[1], n);
      r.qz = scale_unit(c[2], n);
      r.qw = scale_unit(c[3], n);
      r.status = rmq_pkg::STATUS_OK;
      return r;
   endfunction

   // Holds predicted quaternions in order and compares each result against the oldest.
   class quat_scoreboard;
      quat_result_type pending[$];
      int mismatches = 0;
      int checked = 0;
      int rejects = 0;

      function void note_basis(logic [143:0] basis);
         quat_result_type r;
         r = predict_quaternion(basis);
         if (r.status == rmq_pkg::STATUS_REJECT) rejects++;
         pending.push_back(r);
      endfunction

      function void check_quaternion(logic [71:0] data);
         quat_result_type want, got;
         got = data[65:0];
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %h", data);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.qx !== want.qx || got.qy !== want.qy || got.qz !== want.qz ||
             got.qw !== want.qw || got.status !== want.status || data[71:66] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected x=%h y=%h z=%h w=%h st=%0d, got %h",
                        want.qx, want.qy, want.qz, want.qw, want.status, data);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // From bit 0: forward_x, forward_y, forward_z, left_x, left_y, left_z, up_x, up_y, up_z.
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // From bit 0: quat_x, quat_y, quat_z, quat_w, status (2 bits), then zero fill.
   logic [71:0]  rsp_tdata;

   quat_scoreboard board = new();
   int idle_cycles = 0;

   rotation_matrix_to_quaternion_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Scoreboard update and the watchdog both run on the same edge as the handshakes.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_basis(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_quaternion(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results pending", board.pending.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Presents one basis and waits until it is accepted; the gap before it is random
   // unless the caller asks for back to back items. Valid stays high after the
   // handshake, so the caller drops it once the last item has gone.
   task automatic send_basis(logic [143:0] basis, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= basis;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Same as send_basis but with a gap chosen by the caller.
   task automatic stream_basis(logic [143:0] basis, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= basis;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [143:0] pack_basis(int e[9]);
      logic [143:0] b;
      for (int i = 0; i < 9; i++) b[16*i +: 16] = 16'(e[i]);
      return b;
   endfunction

   // A rotation about one axis, built from real cosine and sine values, plus noise.
   function automatic logic [143:0] random_rotation(int noise);
      int e[9];
      int cs, sn, ang, ax, perm;
      real a;
      ang = $urandom_range(0, 359);
      a = ang * 3.14159265358979 / 180.0;
      cs = $rtoi($cos(a) * 16384.0);
      sn = $rtoi($sin(a) * 16384.0);
      ax = $urandom_range(0, 2);
      for (int i = 0; i < 9; i++) e[i] = 0;
      // Column-major: index = 3*col + row.
      case (ax)
         0: begin
            e[0] = 16384; e[4] = cs; e[5] = sn; e[7] = -sn; e[8] = cs;
         end
         1: begin
            e[4] = 16384; e[0] = cs; e[2] = -sn; e[6] = sn; e[8] = cs;
         end
         default: begin
            e[8] = 16384; e[0] = cs; e[1] = sn; e[3] = -sn; e[4] = cs;
         end
      endcase
      // Negating two columns keeps a rotation and reaches the other Shepperd branches.
      perm = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) begin
         if ((perm == 1 && i < 6) || (perm == 2 && (i < 3 || i >= 6)) ||
             (perm == 3 && i >= 3))
            e[i] = -e[i];
      end
      for (int i = 0; i < 9; i++) begin
         e[i] = e[i] + $urandom_range(0, 2 * noise) - noise;
         if (e[i] > 32767) e[i] = 32767;
         if (e[i] < -32768) e[i] = -32768;
      end
      return pack_basis(e);
   endfunction

   // Receiver: draws a random stall, possibly none, before each result.
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      int e[9];
      int gap;
      logic [143:0] b;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, the three half-turn branches, ties on the diagonal,
      // field extremes, and bases just inside and outside the length and dot limits.
      e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};   send_basis(pack_basis(e), 0);
      e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_basis(pack_basis(e), 0);
      e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_basis(pack_basis(e), 0);
      e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_basis(pack_basis(e), 0);
      e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_basis(pack_basis(e), 0);
      e = '{0, 16384, 0, -16384, 0, 0, 0, 0, 16384};  send_basis(pack_basis(e), 0);
      e = '{0, 0, 16384, 16384, 0, 0, 0, 16384, 0};   send_basis(pack_basis(e), 0);
      e = '{0, 16384, 0, 16384, 0, 0, 0, 0, -16384};  send_basis(pack_basis(e), 0);
      e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
      send_basis(pack_basis(e), 0);
      e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
      send_basis(pack_basis(e), 0);
      e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};               send_basis(pack_basis(e), 0);
      // Squared lengths on either side of 0.8 and of 1.2.
      e = '{14655, 0, 0, 0, 16384, 0, 0, 0, 16384};   send_basis(pack_basis(e), 0);
      e = '{14654, 0, 0, 0, 16384, 0, 0, 0, 16384};   send_basis(pack_basis(e), 0);
      e = '{17947, 0, 0, 0, 16384, 0, 0, 0, 16384};   send_basis(pack_basis(e), 0);
      e = '{17948, 0, 0, 0, 16384, 0, 0, 0, 16384};   send_basis(pack_basis(e), 0);
      // Dot product near 0.2 between forward and left.
      e = '{16384, 0, 0, 3276, 16384, 0, 0, 0, 16384}; send_basis(pack_basis(e), 0);
      e = '{16384, 0, 0, 3277, 16384, 0, 0, 0, 16384}; send_basis(pack_basis(e), 0);
      e = '{16384, 0, 0, -3277, 16384, 0, 0, 0, 16384}; send_basis(pack_basis(e), 0);
      // A reflection that passes the basis test.
      e = '{16384, 0, 0, 0, 16384, 0, 0, 0, -16384};  send_basis(pack_basis(e), 0);
      // Trace exactly zero with unequal diagonal.
      e = '{0, 0, 16384, 0, 16384, 0, -16384, 0, -16384}; send_basis(pack_basis(e), 0);
      req_tvalid <= 1'b0;

      // Let the pipeline drain completely before the random part.
      while (board.pending.size() != 0) @(posedge clock);

      for (int k = 0; k < 1340; k++) begin
         case ($urandom_range(0, 9))
            0: for (int i = 0; i < 9; i++) b[16*i +: 16] = 16'($urandom);
            1: b = random_rotation(4000);
            default: b = random_rotation($urandom_range(0, 60));
         endcase
         // Runs of back to back items alternate with runs of random gaps.
         gap = ((k / 100) % 2 == 0) ? 0 : $urandom_range(0, 6);
         stream_basis(b, gap);
         if (k == 700) begin
            req_tvalid <= 1'b0;
            while (board.pending.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Checked %0d quaternions, %0d of them from rejected bases.",
               board.checked, board.rejects);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Mismatches: %0d", board.mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
